// ----- src/pbrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pbrc_pkg;

	localparam int TYPE_BITS = 16;

	typedef enum logic [1:0] {
		OP_QUERY  = 2'd0,
		OP_INSERT = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef struct packed {
		logic                 fire;
		op_t                  op;
		logic [TYPE_BITS-1:0] type_a;
		logic [TYPE_BITS-1:0] type_b;
	} tbl_req_t;

	typedef struct packed {
		logic known;
		logic dropped;
	} tbl_rsp_t;

endpackage

`default_nettype wire

// ----- src/pbrc_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbrc_table import pbrc_pkg::*; #(
	parameter int ENTRIES     = 16,
	parameter int LENGTH_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire tbl_req_t               req,
	input  wire logic [LENGTH_BITS-1:0] range_min,
	input  wire logic [LENGTH_BITS-1:0] range_max,
	output tbl_rsp_t                    rsp,
	output logic      [LENGTH_BITS-1:0] low_bound,
	output logic      [LENGTH_BITS-1:0] high_bound
);

	logic [ENTRIES-1:0]     valid_q;
	logic [TYPE_BITS-1:0]   first_type_q [ENTRIES];
	logic [TYPE_BITS-1:0]   second_type_q [ENTRIES];
	logic [LENGTH_BITS-1:0] low_q [ENTRIES];
	logic [LENGTH_BITS-1:0] high_q [ENTRIES];

	logic [ENTRIES-1:0] hit;
	logic [ENTRIES-1:0] free;
	logic [ENTRIES-1:0] hit_first;
	logic [ENTRIES-1:0] free_first;
	logic [ENTRIES-1:0] wr_vec;
	logic               any_hit;
	logic               any_free;

	// tag match in either order, lowest entry wins
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit[i] = valid_q[i] &&
				((first_type_q[i] == req.type_a && second_type_q[i] == req.type_b) ||
				 (first_type_q[i] == req.type_b && second_type_q[i] == req.type_a));
		end
		free       = ~valid_q;
		hit_first  = hit & (~hit + ENTRIES'(1));
		free_first = free & (~free + ENTRIES'(1));
		any_hit    = |hit;
		any_free   = |free;
	end

	always_comb begin
		low_bound  = '0;
		high_bound = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			low_bound  = low_bound | ({LENGTH_BITS{hit_first[i]}} & low_q[i]);
			high_bound = high_bound | ({LENGTH_BITS{hit_first[i]}} & high_q[i]);
		end
	end

	always_comb begin
		wr_vec = '0;
		if (req.fire && req.op == OP_INSERT) begin
			wr_vec = any_hit ? hit_first : free_first;
		end
		rsp.known   = (req.op == OP_QUERY) && any_hit;
		rsp.dropped = (req.op == OP_INSERT) && !any_hit && !any_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.fire && req.op == OP_CLEAR) begin
			valid_q <= '0;
		end else begin
			valid_q <= valid_q | wr_vec;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (wr_vec[i]) begin
				first_type_q[i]  <= req.type_a;
				second_type_q[i] <= req.type_b;
				low_q[i]         <= range_min;
				high_q[i]        <= range_max;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/pair_type_bond_range_check_unit.sv -----
// Path: stage one, stage two, stage three, then the output register holds the result.
// Throughput: one transaction per cycle; the table tag compare and update in stage one
// sets this, each item seeing every earlier insert and clear; result_stall can stall it.
// Reset: clears the table valid bits and all stage valids; entry contents are not reset.
`timescale 1ns / 1ps
`default_nettype none

module pair_type_bond_range_check_unit import pbrc_pkg::*; #(
	parameter int TABLE_ENTRIES = 16,
	parameter int COORD_BITS    = 24,
	parameter int LENGTH_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic        [1:0]             opcode,
	input  wire logic        [TYPE_BITS-1:0]   type_a,
	input  wire logic        [TYPE_BITS-1:0]   type_b,
	input  wire logic signed [COORD_BITS-1:0]  first_x,
	input  wire logic signed [COORD_BITS-1:0]  first_y,
	input  wire logic signed [COORD_BITS-1:0]  first_z,
	input  wire logic signed [COORD_BITS-1:0]  second_x,
	input  wire logic signed [COORD_BITS-1:0]  second_y,
	input  wire logic signed [COORD_BITS-1:0]  second_z,
	input  wire logic        [LENGTH_BITS-1:0] range_min,
	input  wire logic        [LENGTH_BITS-1:0] range_max,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic                               bonded,
	output logic                               pair_known,
	output logic                               insert_dropped
);

	localparam int MAG_W = LENGTH_BITS + 1;
	localparam int MW    = (COORD_BITS > MAG_W) ? COORD_BITS : MAG_W;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int BSQ_W = 2 * LENGTH_BITS;
	localparam logic [MW-1:0] CAP = MW'(1) << LENGTH_BITS;

	// stage one: input register
	logic                   v_s1;
	op_t                    op_s1;
	logic [TYPE_BITS-1:0]   type_a_s1;
	logic [TYPE_BITS-1:0]   type_b_s1;
	logic [COORD_BITS-1:0]  first_s1 [3];
	logic [COORD_BITS-1:0]  second_s1 [3];
	logic [LENGTH_BITS-1:0] range_min_s1;
	logic [LENGTH_BITS-1:0] range_max_s1;

	// stage two: capped axis differences and bounds
	logic                   v_s2;
	logic                   known_s2;
	logic                   dropped_s2;
	logic [MAG_W-1:0]       mag_s2 [3];
	logic [LENGTH_BITS-1:0] low_s2;
	logic [LENGTH_BITS-1:0] high_s2;

	// stage three: squares
	logic                   v_s3;
	logic                   known_s3;
	logic                   dropped_s3;
	logic [SQ_W-1:0]        sq_s3 [3];
	logic [BSQ_W-1:0]       low_sq_s3;
	logic [BSQ_W-1:0]       high_sq_s3;

	logic bonded_q;
	logic known_q;
	logic dropped_q;

	logic en_out;
	logic en3;
	logic en2;
	logic en1;

	tbl_req_t               req;
	tbl_rsp_t               rsp;
	logic [LENGTH_BITS-1:0] low_bound;
	logic [LENGTH_BITS-1:0] high_bound;

	logic [COORD_BITS:0]    diff [3];
	logic [COORD_BITS:0]    negd [3];
	logic [COORD_BITS-1:0]  absd [3];
	logic [MW-1:0]          absx [3];
	logic [MAG_W-1:0]       mag [3];
	logic [SUM_W-1:0]       dist_sq;

	assign en_out     = !result_valid || !result_stall;
	assign en3        = !v_s3 || en_out;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign item_stall = !en1;

	assign req.fire   = v_s1 && en2;
	assign req.op     = op_s1;
	assign req.type_a = type_a_s1;
	assign req.type_b = type_b_s1;

	pbrc_table #(
		.ENTRIES     (TABLE_ENTRIES),
		.LENGTH_BITS (LENGTH_BITS)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.range_min  (range_min_s1),
		.range_max  (range_max_s1),
		.rsp        (rsp),
		.low_bound  (low_bound),
		.high_bound (high_bound)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = {second_s1[k][COORD_BITS-1], second_s1[k]} -
				{first_s1[k][COORD_BITS-1], first_s1[k]};
			negd[k] = -diff[k];
			absd[k] = diff[k][COORD_BITS] ? negd[k][COORD_BITS-1:0] : diff[k][COORD_BITS-1:0];
			absx[k] = MW'(absd[k]);
			mag[k]  = (absx[k] > CAP) ? CAP[MAG_W-1:0] : absx[k][MAG_W-1:0];
		end
		dist_sq = SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= item_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				result_valid <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1        <= op_t'(opcode);
			type_a_s1    <= type_a;
			type_b_s1    <= type_b;
			first_s1[0]  <= first_x;
			first_s1[1]  <= first_y;
			first_s1[2]  <= first_z;
			second_s1[0] <= second_x;
			second_s1[1] <= second_y;
			second_s1[2] <= second_z;
			range_min_s1 <= range_min;
			range_max_s1 <= range_max;
		end
		if (en2) begin
			known_s2   <= rsp.known;
			dropped_s2 <= rsp.dropped;
			mag_s2     <= mag;
			low_s2     <= low_bound;
			high_s2    <= high_bound;
		end
		if (en3) begin
			known_s3   <= known_s2;
			dropped_s3 <= dropped_s2;
			for (int k = 0; k < 3; k++) begin
				sq_s3[k] <= mag_s2[k] * mag_s2[k];
			end
			low_sq_s3  <= low_s2 * low_s2;
			high_sq_s3 <= high_s2 * high_s2;
		end
		if (en_out) begin
			bonded_q  <= known_s3 && (dist_sq >= SUM_W'(low_sq_s3)) &&
				(dist_sq <= SUM_W'(high_sq_s3));
			known_q   <= known_s3;
			dropped_q <= dropped_s3;
		end
	end

	assign bonded         = bonded_q;
	assign pair_known     = known_q;
	assign insert_dropped = dropped_q;

`ifndef SYNTH
	a_bonded_needs_known: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bonded |-> pair_known)
		else $error("bonded without a known pair");

	a_known_drop_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(pair_known && insert_dropped))
		else $error("query and insert flags both set");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> v_s1 && v_s2 && v_s3 && result_valid && result_stall)
		else $error("input stalled with room in the pipeline");

	a_result_from_stage3: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(v_s3))
		else $error("result appeared with no transaction in stage three");
`endif

endmodule

`default_nettype wire
